// File: rtl/mii_phy_management_registers_unit_assert.svh
// ----------------------------------------------------------------------------
// mii_phy_management_registers_unit_assert
// Assertion macros shared by the MII management register block.
// ----------------------------------------------------------------------------
`ifndef MII_PHY_MANAGEMENT_REGISTERS_UNIT_ASSERT_SVH
`define MII_PHY_MANAGEMENT_REGISTERS_UNIT_ASSERT_SVH

// Same-cycle implication, checked on aclk, off while in reset.
`define MPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mpr assertion failed");

// Next-cycle implication, checked on aclk, off while in reset.
`define MPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mpr assertion failed");

`endif

// File: rtl/mpr_pkg.sv
// ----------------------------------------------------------------------------
// mpr_pkg
// Types and constants for the MII management command and PHY register file.
// ----------------------------------------------------------------------------
package mpr_pkg;

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_LINK  = 2'd2;

    // Command word bit positions
    localparam int CMD_BUSY_BIT  = 4;
    localparam int CMD_WRITE_BIT = 5;

    // PHY register indexes
    localparam logic [4:0] PHY_REG_BMCR = 5'd0;
    localparam logic [4:0] PHY_REG_BMSR = 5'd1;
    localparam logic [4:0] PHY_REG_ID1  = 5'd2;
    localparam logic [4:0] PHY_REG_ID2  = 5'd3;
    localparam logic [4:0] PHY_REG_PSSR = 5'd17;

    localparam int BMCR_RESET_BIT = 15;
    localparam int BMSR_LINK_BIT  = 2;
    localparam int PSSR_LINK_BIT  = 10;

    localparam logic [15:0] BMCR_DEFAULT      = 16'h1140;
    localparam logic [15:0] BMSR_DEFAULT      = 16'h78ED;
    localparam logic [15:0] VENDOR_ID_DEFAULT = 16'h0141;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] write_data;
        logic        link_state;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        link_irq;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic cfg_wr;
    } ctrl_cmd_t;

    function automatic logic [15:0] phy_reset_value(input logic [4:0] idx);
        logic [15:0] val;
        unique case (idx)
            5'd0:    val = BMCR_DEFAULT;
            5'd1:    val = BMSR_DEFAULT;
            5'd3:    val = 16'h0CC2;
            5'd4:    val = 16'h05E1;
            5'd5:    val = 16'h45E1;
            5'd6:    val = 16'h000F;
            5'd9:    val = 16'h0300;
            5'd10:   val = 16'h7C00;
            5'd17:   val = 16'hAC00;
            default: val = 16'h0000;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/mpr_controller.sv
// ----------------------------------------------------------------------------
// mpr_controller
// Sequencer: take a request, run it through the datapath, hold the response.
// ----------------------------------------------------------------------------
`include "mii_phy_management_registers_unit_assert.svh"

module mpr_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    output mpr_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_RESP);
    assign cfg_ready   = 1'b1;
    assign cmd.capture = s_valid && s_ready;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign cmd.cfg_wr  = cfg_valid;

    `MPR_ASSERT_NEXT(a_accept_to_exec, s_valid && s_ready, state_reg == ST_EXEC)
    `MPR_ASSERT_NOW(a_one_phase, 1'b1, $onehot0({s_ready, cmd.execute, m_valid}))
    `MPR_ASSERT_NEXT(a_transfer_frees, m_valid && m_ready, s_ready && !m_valid)

endmodule

// File: rtl/mpr_datapath.sv
// ----------------------------------------------------------------------------
// mpr_datapath
// Command register, PHY register file, link state and response register.
// ----------------------------------------------------------------------------
module mpr_datapath #(
    parameter int PHY_REG_COUNT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mpr_pkg::ctrl_cmd_t cmd,
    input  mpr_pkg::req_t      s_data,
    input  logic [15:0]        cfg_data,
    output mpr_pkg::rsp_t      m_data
);

    localparam int IDX_W = $clog2(PHY_REG_COUNT);

    mpr_pkg::req_t req_reg;
    mpr_pkg::rsp_t rsp_reg;
    mpr_pkg::rsp_t rsp_next;

    logic [15:0] phy_regs_reg  [PHY_REG_COUNT];
    logic [15:0] phy_regs_next [PHY_REG_COUNT];
    logic [31:0] command_reg;
    logic [31:0] command_next;
    logic        link_up_reg;
    logic        link_up_next;
    logic [15:0] vendor_id_reg;

    logic [4:0]       wr_field;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      wr_value;
    logic [4:0]       rd_field;
    logic [IDX_W-1:0] rd_idx;
    logic [15:0]      rd_value;

    assign wr_field = req_reg.write_data[15:11];
    assign wr_idx   = wr_field[IDX_W-1:0];
    assign wr_value = req_reg.write_data[31:16];
    assign rd_field = command_reg[15:11];
    assign rd_idx   = rd_field[IDX_W-1:0];
    assign rd_value = (rd_field == mpr_pkg::PHY_REG_ID1) ? vendor_id_reg : phy_regs_reg[rd_idx];

    always_comb begin
        phy_regs_next = phy_regs_reg;
        command_next  = command_reg;
        link_up_next  = link_up_reg;
        rsp_next      = rsp_reg;
        if (cmd.execute) begin
            rsp_next = '0;
            unique case (req_reg.req_type)
                mpr_pkg::REQ_WRITE: begin
                    command_next = req_reg.write_data;
                    if (req_reg.write_data[mpr_pkg::CMD_WRITE_BIT]) begin
                        if (wr_field == mpr_pkg::PHY_REG_BMCR
                            && wr_value[mpr_pkg::BMCR_RESET_BIT]) begin
                            phy_regs_next[mpr_pkg::PHY_REG_BMCR] = mpr_pkg::BMCR_DEFAULT;
                            phy_regs_next[mpr_pkg::PHY_REG_BMSR] = mpr_pkg::BMSR_DEFAULT;
                        end else if (wr_field != mpr_pkg::PHY_REG_ID1
                                     && wr_field != mpr_pkg::PHY_REG_ID2) begin
                            phy_regs_next[wr_idx] = wr_value;
                        end
                        command_next[mpr_pkg::CMD_BUSY_BIT] = 1'b0;
                    end
                end
                mpr_pkg::REQ_READ: begin
                    if (command_reg[mpr_pkg::CMD_BUSY_BIT]) begin
                        command_next = {rd_value, 16'h0000};
                    end
                    rsp_next.read_data = command_next;
                end
                mpr_pkg::REQ_LINK: begin
                    if (req_reg.link_state != link_up_reg) begin
                        link_up_next = req_reg.link_state;
                        phy_regs_next[mpr_pkg::PHY_REG_BMSR][mpr_pkg::BMSR_LINK_BIT] =
                            req_reg.link_state;
                        phy_regs_next[mpr_pkg::PHY_REG_PSSR][mpr_pkg::PSSR_LINK_BIT] =
                            req_reg.link_state;
                        rsp_next.link_irq = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PHY_REG_COUNT; i++) begin
                phy_regs_reg[i] <= mpr_pkg::phy_reset_value(5'(i));
            end
            command_reg   <= '0;
            link_up_reg   <= 1'b1;
            vendor_id_reg <= mpr_pkg::VENDOR_ID_DEFAULT;
        end else begin
            phy_regs_reg <= phy_regs_next;
            command_reg  <= command_next;
            link_up_reg  <= link_up_next;
            if (cmd.cfg_wr) begin
                vendor_id_reg <= cfg_data;
            end
        end
    end

    assign m_data = rsp_reg;

endmodule

// File: rtl/mii_phy_management_registers_unit.sv
// ----------------------------------------------------------------------------
// mii_phy_management_registers_unit
// MII management command register with the PHY register file behind it.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request (command write, command read or link event);
//   m_* returns one response per request: read_data and link_irq.
//   cfg_* writes the PHY identifier word of register 2 and is always ready;
//   the user must write it only while no request is in flight; not enforced.
// Timing:
//   A request is taken in the idle state, executed in the next cycle and
//   its response is valid the cycle after. One request is in flight at a
//   time: a new request is not taken until the response has been accepted,
//   as the three-state sequencer sets.
// Reset:
//   aresetn low restores the PHY register defaults, clears the command
//   register, marks the link up and loads the default identifier word.
// Stall:
//   While m_ready is low the response holds and s_ready stays low.
// ----------------------------------------------------------------------------
module mii_phy_management_registers_unit #(
    parameter int PHY_REG_COUNT = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mpr_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mpr_pkg::rsp_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);

    mpr_pkg::ctrl_cmd_t cmd;

    mpr_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    mpr_datapath #(
        .PHY_REG_COUNT (PHY_REG_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule
